/* sv/isd_pkg.sv */
// Shared constants and types for the integrating switch debouncer.
`default_nettype none

package isd_pkg;

   // Field widths
   localparam int NOW_BITS      = 32;
   localparam int MS_BITS       = 23;
   localparam int COUNT_BITS    = 32;
   localparam int PERIOD_BITS   = 16;
   localparam int THR_BITS      = 8;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam int TIME_BITS_DEFAULT = 32;

   // Ceiling applied to the programmed threshold (fits 16 bits).
   localparam int unsigned MAX_THRESHOLD = 255;

   // Register reset values
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET     = 16'd1000;
   localparam logic [THR_BITS-1:0]    THRESHOLD_RESET  = 8'd5;
   localparam logic                   ACTIVE_LOW_RESET = 1'b1;

   // Microsecond to millisecond conversion.
   // us / 1000 = (us >> 3) / 125, and /125 is a multiply by
   // ceil(2^37 / 125) followed by a right shift of 37. Exact for any
   // 30-bit dividend.
   localparam logic [63:0] US_PER_MS   = 64'd1000;
   localparam logic [63:0] MS_MAX      = 64'h7F_FFFF;
   localparam logic [63:0] SAT_US      = MS_MAX * US_PER_MS;
   localparam int          DIV_IN_BITS = 33;
   localparam int          PRE_SHIFT   = 3;
   localparam int          Y_BITS      = DIV_IN_BITS - PRE_SHIFT;
   localparam int          RECIP_BITS  = 31;
   localparam int          RECIP_SHIFT = 37;
   localparam int          PROD_BITS   = Y_BITS + RECIP_BITS;
   localparam logic [RECIP_BITS-1:0] RECIP_125 = 31'd1099511628;

   // CSR register indexes (byte address = 4 * index)
   typedef enum logic [1:0] {
      REG_SAMPLE_PERIOD    = 2'd0,
      REG_ACTIVE_THRESHOLD = 2'd1,
      REG_ACTIVE_LOW       = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

/* sv/isd_req_if.sv */
// Poll channel: timestamp and raw pin level.
`default_nettype none

interface isd_req_if;
   logic                          valid;
   logic                          ready;
   logic [isd_pkg::NOW_BITS-1:0]  now_us;
   logic                          pin_level;

   modport source (output valid, output now_us, output pin_level, input ready);
   modport sink   (input valid, input now_us, input pin_level, output ready);
endinterface

`default_nettype wire

/* sv/isd_rsp_if.sv */
// Result channel: debounced state and press statistics.
`default_nettype none

interface isd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           pressed;
   logic [isd_pkg::COUNT_BITS-1:0] press_count;
   logic [isd_pkg::MS_BITS-1:0]    last_press_ms;
   logic [isd_pkg::MS_BITS-1:0]    state_age_ms;

   modport source (output valid, output pressed, output press_count,
                   output last_press_ms, output state_age_ms, input ready);
   modport sink   (input valid, input pressed, input press_count,
                   input last_press_ms, input state_age_ms, output ready);
endinterface

`default_nettype wire

/* sv/integrating_switch_debouncer.sv */
// Integrating switch debouncer: top level with CSR block and two-stage datapath.
//
// Every poll transaction (timestamp plus raw pin level) yields exactly one
// result transaction. Throughput is one transaction per clock while results are
// taken; a result is valid on rsp_bus once its poll has passed through the
// stage-1 register and the result register. The debounce
// state (sample timer, saturating integrator, pressed flag, press counter)
// is updated in the accept cycle, so back-to-back polls chain through it
// directly. The microsecond-to-millisecond conversion is a reciprocal
// multiply that sits in the second stage, between the stage-1 register and
// the result register. req_bus.ready drops only while both stages hold a
// transaction and the result is not being taken. CSRs: sample period at
// 0x0, threshold at 0x4, active-low polarity at 0x8; write them only while
// the block is idle.
`default_nettype none

module integrating_switch_debouncer #(
   parameter int TIME_BITS = isd_pkg::TIME_BITS_DEFAULT   // timestamp wrap width, 16..64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // CSR port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [isd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [isd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic      [isd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                     csr_pready,
   // Streams
   isd_req_if.sink                                  req_bus,
   isd_rsp_if.source                                rsp_bus
);

   // Compare width for the saturation check: wide enough for SAT_US.
   localparam int CMP_BITS = (TIME_BITS > isd_pkg::DIV_IN_BITS) ?
                             TIME_BITS : isd_pkg::DIV_IN_BITS;

   //------------------------------------------------------------------
   // CSRs
   //------------------------------------------------------------------
   logic [isd_pkg::PERIOD_BITS-1:0] sample_period_ff, sample_period_in;
   logic [isd_pkg::THR_BITS-1:0]    threshold_ff, threshold_in;
   logic                            active_low_ff, active_low_in;

   isd_pkg::csr_index_type csr_index;
   logic                   csr_write;

   always_comb begin
      csr_index        = isd_pkg::csr_index_type'(csr_paddr[3:2]);
      csr_write        = csr_psel && csr_penable && csr_pwrite;
      csr_pready       = 1'b1;
      sample_period_in = sample_period_ff;
      threshold_in     = threshold_ff;
      active_low_in    = active_low_ff;
      csr_prdata       = '0;
      unique case (csr_index)
         isd_pkg::REG_SAMPLE_PERIOD: begin
            csr_prdata = isd_pkg::CSR_DATA_BITS'(sample_period_ff);
            if (csr_write) sample_period_in = csr_pwdata[isd_pkg::PERIOD_BITS-1:0];
         end
         isd_pkg::REG_ACTIVE_THRESHOLD: begin
            csr_prdata = isd_pkg::CSR_DATA_BITS'(threshold_ff);
            if (csr_write) threshold_in = csr_pwdata[isd_pkg::THR_BITS-1:0];
         end
         isd_pkg::REG_ACTIVE_LOW: begin
            csr_prdata = isd_pkg::CSR_DATA_BITS'(active_low_ff);
            if (csr_write) active_low_in = csr_pwdata[0];
         end
         default: begin
            // unmapped: reads zero, writes dropped
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= isd_pkg::PERIOD_RESET;
         threshold_ff     <= isd_pkg::THRESHOLD_RESET;
         active_low_ff    <= isd_pkg::ACTIVE_LOW_RESET;
      end else begin
         sample_period_ff <= sample_period_in;
         threshold_ff     <= threshold_in;
         active_low_ff    <= active_low_in;
      end
   end

   //------------------------------------------------------------------
   // Pipeline handshake
   //------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s2_en;      // result register may load
   logic accept;

   always_comb begin
      s2_en         = !rsp_valid_ff || rsp_bus.ready;
      req_bus.ready = !s1_valid_ff || s2_en;
      accept        = req_bus.valid && req_bus.ready;
   end

   //------------------------------------------------------------------
   // Stage 1: debounce state update in the accept cycle
   //------------------------------------------------------------------
   logic [TIME_BITS-1:0]             last_sample_ff, last_sample_in;
   logic [TIME_BITS-1:0]             state_start_ff, state_start_in;
   logic [isd_pkg::THR_BITS-1:0]     integrator_ff, integrator_in;
   logic                             debounced_ff, debounced_in;
   logic [isd_pkg::COUNT_BITS-1:0]   press_cnt_ff, press_cnt_in;

   logic                             s1_changed_ff, s1_changed_in;
   logic                             s1_released_ff, s1_released_in;
   logic [isd_pkg::Y_BITS-1:0]       s1_y_ff, s1_y_in;

   logic [TIME_BITS-1:0]             now_t, samp_diff, state_diff;
   logic [isd_pkg::THR_BITS-1:0]     thr, integ_step;
   logic                             sample_hit, at_end, settled, changed;
   logic [CMP_BITS-1:0]              diff_wide;
   logic [isd_pkg::DIV_IN_BITS-1:0]  diff_clamp;

   always_comb begin
      now_t = TIME_BITS'(req_bus.now_us);
      // effective ceiling: min(threshold, MAX_THRESHOLD)
      thr = ({8'd0, threshold_ff} > 16'(isd_pkg::MAX_THRESHOLD)) ?
            isd_pkg::THR_BITS'(isd_pkg::MAX_THRESHOLD) : threshold_ff;

      samp_diff  = now_t - last_sample_ff;
      sample_hit = samp_diff >= TIME_BITS'(sample_period_ff);

      // saturating integrator, moved only on a sample
      integ_step = integrator_ff;
      if (sample_hit) begin
         if (req_bus.pin_level) begin
            if (integrator_ff < thr) integ_step = integrator_ff + 8'd1;
         end else if (integrator_ff != '0) begin
            integ_step = integrator_ff - 8'd1;
         end
      end

      // state is only decided at either end of the integrator range
      at_end  = (integ_step == thr) || (integ_step == '0);
      settled = active_low_ff ? (integ_step == '0) : (integ_step != '0);
      changed = at_end && (settled != debounced_ff);

      // time in current state, clamped so the ms result saturates at 2^23-1
      state_diff = now_t - state_start_ff;
      diff_wide  = CMP_BITS'(state_diff);
      diff_clamp = (diff_wide >= CMP_BITS'(isd_pkg::SAT_US)) ?
                   isd_pkg::DIV_IN_BITS'(isd_pkg::SAT_US) :
                   diff_wide[isd_pkg::DIV_IN_BITS-1:0];

      last_sample_in = last_sample_ff;
      integrator_in  = integrator_ff;
      debounced_in   = debounced_ff;
      state_start_in = state_start_ff;
      press_cnt_in   = press_cnt_ff;
      s1_changed_in  = s1_changed_ff;
      s1_released_in = s1_released_ff;
      s1_y_in        = s1_y_ff;

      if (accept) begin
         if (sample_hit) last_sample_in = now_t;
         integrator_in = integ_step;
         if (changed) begin
            debounced_in   = settled;
            state_start_in = now_t;
            if (settled) press_cnt_in = press_cnt_ff + 32'd1;
         end
         s1_changed_in  = changed;
         s1_released_in = changed && !settled;
         s1_y_in        = diff_clamp[isd_pkg::DIV_IN_BITS-1:isd_pkg::PRE_SHIFT];
      end

      if (accept)     s1_valid_in = 1'b1;
      else if (s2_en) s1_valid_in = 1'b0;
      else            s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         state_start_ff <= '0;
         integrator_ff  <= '0;
         debounced_ff   <= 1'b0;
         press_cnt_ff   <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         last_sample_ff <= last_sample_in;
         state_start_ff <= state_start_in;
         integrator_ff  <= integrator_in;
         debounced_ff   <= debounced_in;
         press_cnt_ff   <= press_cnt_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_changed_ff  <= s1_changed_in;
      s1_released_ff <= s1_released_in;
      s1_y_ff        <= s1_y_in;
   end

   //------------------------------------------------------------------
   // Stage 2: us -> ms by reciprocal multiply, into the result register
   //------------------------------------------------------------------
   logic [isd_pkg::PROD_BITS-1:0]  prod;
   logic [isd_pkg::MS_BITS-1:0]    quo;
   logic                           load_rsp;

   logic                           rsp_pressed_ff, rsp_pressed_in;
   logic [isd_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [isd_pkg::MS_BITS-1:0]    rsp_age_ff, rsp_age_in;
   logic [isd_pkg::MS_BITS-1:0]    press_len_ff, press_len_in;

   always_comb begin
      prod     = isd_pkg::PROD_BITS'(s1_y_ff) * isd_pkg::PROD_BITS'(isd_pkg::RECIP_125);
      quo      = prod[isd_pkg::RECIP_SHIFT+isd_pkg::MS_BITS-1:isd_pkg::RECIP_SHIFT];
      load_rsp = s2_en && s1_valid_ff;

      rsp_valid_in   = s2_en ? s1_valid_ff : rsp_valid_ff;
      rsp_pressed_in = rsp_pressed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_age_in     = rsp_age_ff;
      press_len_in   = press_len_ff;
      if (load_rsp) begin
         // debounced_ff and press_cnt_ff still match the stage-1 transaction
         rsp_pressed_in = debounced_ff;
         rsp_count_in   = press_cnt_ff;
         rsp_age_in     = s1_changed_ff ? '0 : quo;
         if (s1_released_ff) press_len_in = quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         press_len_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         press_len_ff <= press_len_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_age_ff     <= rsp_age_in;
   end

   always_comb begin
      rsp_bus.valid         = rsp_valid_ff;
      rsp_bus.pressed       = rsp_pressed_ff;
      rsp_bus.press_count   = rsp_count_ff;
      rsp_bus.last_press_ms = press_len_ff;
      rsp_bus.state_age_ms  = rsp_age_ff;
   end

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // press counter steps by one, and only on entry into pressed
   a_press_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && press_cnt_ff != $past(press_cnt_ff)) |->
      (press_cnt_ff == $past(press_cnt_ff) + 32'd1) && debounced_ff && !$past(debounced_ff))
      else $error("press counter moved without a press");

   // input side only stalls while both stages are full and output is blocked
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_bus.ready)
      else $error("input stalled with room in the pipeline");

   // a transaction that changed state reports zero age
   a_age_on_change: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_en && s1_changed_ff) |=> (rsp_bus.state_age_ms == '0))
      else $error("state change reported nonzero age");

   // press length only updates when a release leaves stage 1
   a_press_len_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && press_len_ff != $past(press_len_ff)) |->
      $past(s1_valid_ff && s2_en && s1_released_ff))
      else $error("press length changed without a release");

endmodule

`default_nettype wire
